// ===== hdl/rei_pkg.sv =====
// ---------------------------------------------------------------------------
// Rotary encoder interface package
// Shared constants, register map and the quadrature step decoder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rei_pkg;

    // Width of the free-running microsecond timestamps.
    localparam int TIME_BITS = 48;

    // Speed numerator: half-steps per second scaled to detents per second.
    localparam int SPEED_NUM = 500000;
    localparam int QUO_BITS  = 19;

    // Field widths.
    localparam int POS_BITS   = 31;
    localparam int COUNT_BITS = 32;
    localparam int SPEED_BITS = 19;
    localparam int BAND_BITS  = 10;
    localparam int TMO_BITS   = 24;
    localparam int AVG_BITS   = 28;
    localparam int ADDR_BITS  = 5;
    localparam int DATA_BITS  = 32;

    // Request codes. The spare code is accepted and ignored.
    localparam logic [1:0] REQ_ENC   = 2'd0;
    localparam logic [1:0] REQ_BTN   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_SPARE = 2'd3;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_INVERT   = 3'd0;
    localparam logic [2:0] REG_MEDIUM   = 3'd1;
    localparam logic [2:0] REG_FAST     = 3'd2;
    localparam logic [2:0] REG_BAND     = 3'd3;
    localparam logic [2:0] REG_STALE    = 3'd4;
    localparam logic [2:0] REG_DEBOUNCE = 3'd5;

    // Register reset values.
    localparam logic [SPEED_BITS-1:0] MEDIUM_RST   = SPEED_BITS'(80);
    localparam logic [SPEED_BITS-1:0] FAST_RST     = SPEED_BITS'(300);
    localparam logic [BAND_BITS-1:0]  BAND_RST     = BAND_BITS'(5);
    localparam logic [TMO_BITS-1:0]   STALE_RST    = TMO_BITS'(150000);
    localparam logic [TMO_BITS-1:0]   DEBOUNCE_RST = TMO_BITS'(20000);

    // Speed tiers.
    localparam logic [1:0] TIER_SLOW   = 2'd0;
    localparam logic [1:0] TIER_MEDIUM = 2'd1;
    localparam logic [1:0] TIER_FAST   = 2'd2;

    // Quadrature step results.
    localparam logic [1:0] STEP_NONE = 2'd0;
    localparam logic [1:0] STEP_UP   = 2'd1;
    localparam logic [1:0] STEP_DOWN = 2'd2;

    // Pins are packed as {A, B}. The forward order is 00, 10, 11, 01.
    function automatic logic [1:0] gray_step(input logic [1:0] prev, input logic [1:0] cur);
        logic [1:0] step;
        unique case ({prev, cur}) inside
            4'b0010, 4'b1011, 4'b1101, 4'b0100: step = STEP_UP;
            4'b0001, 4'b0111, 4'b1110, 4'b1000: step = STEP_DOWN;
            default:                            step = STEP_NONE;
        endcase
        return step;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/rotary_encoder_interface.sv =====
// ---------------------------------------------------------------------------
// Rotary encoder interface
// Quadrature decoder with a debounced push button and a smoothed speed
// estimate reported, with a speed tier, on each read request.
// ---------------------------------------------------------------------------
// Encoder and button beats are absorbed in the cycle they are accepted and
// can follow one another back to back. A read beat walks the sequencer through
// the age, interval, divide, average and finish steps, the finish step waiting
// only while an unclaimed result is held, and the sequencer is idle again for
// the next beat as the result is presented; the serial divider forms 500000 / edge interval.
// Reset (synchronous, active low) clears the state and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none

module rotary_encoder_interface (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Event channel
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [1:0]                      i_req_type,
    input  wire logic                            i_pin_a,
    input  wire logic                            i_pin_b,
    input  wire logic                            i_pin_switch,
    input  wire logic [rei_pkg::TIME_BITS-1:0]   i_time_us,
    // Result channel
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic signed [rei_pkg::POS_BITS-1:0]  o_position,
    output logic                                 o_pressed,
    output logic                                 o_btn_event,
    output logic [rei_pkg::SPEED_BITS-1:0]       o_smooth_speed,
    output logic [1:0]                           o_speed_tier,
    // Configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [rei_pkg::ADDR_BITS-1:0]   paddr,
    input  wire logic [rei_pkg::DATA_BITS-1:0]   pwdata,
    output logic [rei_pkg::DATA_BITS-1:0]        prdata,
    output logic                                 pready
);
    import rei_pkg::*;

    // Read sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_AGE  = 3'd1;
    localparam logic [2:0] S_INTV = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_AVG  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                  r_invert;
    logic [SPEED_BITS-1:0] r_medium;
    logic [SPEED_BITS-1:0] r_fast;
    logic [BAND_BITS-1:0]  r_band;
    logic [TMO_BITS-1:0]   r_stale_time;
    logic [TMO_BITS-1:0]   r_debounce;
    logic                  w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert     <= 1'b0;
            r_medium     <= MEDIUM_RST;
            r_fast       <= FAST_RST;
            r_band       <= BAND_RST;
            r_stale_time <= STALE_RST;
            r_debounce   <= DEBOUNCE_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                REG_INVERT:   r_invert     <= pwdata[0];
                REG_MEDIUM:   r_medium     <= pwdata[SPEED_BITS-1:0];
                REG_FAST:     r_fast       <= pwdata[SPEED_BITS-1:0];
                REG_BAND:     r_band       <= pwdata[BAND_BITS-1:0];
                REG_STALE:    r_stale_time <= pwdata[TMO_BITS-1:0];
                REG_DEBOUNCE: r_debounce   <= pwdata[TMO_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_INVERT:   prdata = DATA_BITS'(r_invert);
            REG_MEDIUM:   prdata = DATA_BITS'(r_medium);
            REG_FAST:     prdata = DATA_BITS'(r_fast);
            REG_BAND:     prdata = DATA_BITS'(r_band);
            REG_STALE:    prdata = DATA_BITS'(r_stale_time);
            REG_DEBOUNCE: prdata = DATA_BITS'(r_debounce);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Event intake. Encoder and button beats update state right at the
    // accepting edge; a read beat latches its timestamp and starts the
    // sequencer.
    // ------------------------------------------------------------------
    logic [2:0]            r_state;
    logic                  w_accept;
    logic [1:0]            w_cur_pins;
    logic [1:0]            w_step;
    logic [TIME_BITS-1:0]  w_btn_age;
    logic                  w_btn_level;

    logic [COUNT_BITS-1:0] r_edge_count;
    logic [1:0]            r_prev_pins;
    logic [TIME_BITS-1:0]  r_older_time;
    logic [TIME_BITS-1:0]  r_latest_time;
    logic [1:0]            r_edges_seen;
    logic                  r_btn_level;
    logic                  r_btn_flag;
    logic [TIME_BITS-1:0]  r_btn_time;
    logic [TIME_BITS-1:0]  r_now;

    assign o_ready     = (r_state == S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_cur_pins  = {i_pin_a, i_pin_b};
    assign w_step      = gray_step(r_prev_pins, w_cur_pins);
    assign w_btn_age   = i_time_us - r_btn_time;
    assign w_btn_level = ~i_pin_switch;

    // Result-side signals from the sequencer below.
    logic                  w_fin_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge_count  <= '0;
            r_prev_pins   <= '0;
            r_older_time  <= '0;
            r_latest_time <= '0;
            r_edges_seen  <= '0;
            r_btn_level   <= 1'b0;
            r_btn_flag    <= 1'b0;
            r_btn_time    <= '0;
        end else begin
            if (w_accept && i_req_type == REQ_ENC) begin
                r_prev_pins <= w_cur_pins;
                if (w_step != STEP_NONE) begin
                    r_edge_count  <= (w_step == STEP_UP) ? r_edge_count + 1'b1
                                                         : r_edge_count - 1'b1;
                    r_older_time  <= r_latest_time;
                    r_latest_time <= i_time_us;
                    if (r_edges_seen != 2'd2) begin
                        r_edges_seen <= r_edges_seen + 1'b1;
                    end
                end
            end
            // A button change counts only once the debounce window has passed.
            if (w_accept && i_req_type == REQ_BTN &&
                w_btn_age >= TIME_BITS'(r_debounce) && w_btn_level != r_btn_level) begin
                r_btn_level <= w_btn_level;
                r_btn_flag  <= 1'b1;
                r_btn_time  <= i_time_us;
            end
            // The read that reports the flag also clears it.
            if (w_fin_go) begin
                r_btn_flag <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now <= i_time_us;
        end
    end

    // ------------------------------------------------------------------
    // Read sequencer: age check, interval and position, serial division,
    // average update, then tier update and result hand-off.
    // ------------------------------------------------------------------
    logic                       r_stale;
    logic                       r_inst_ok;
    logic signed [POS_BITS-1:0] r_pos;
    logic [AVG_BITS-1:0]        r_avg;
    logic [1:0]                 r_tier;
    logic                       r_div_start;

    logic [TIME_BITS-1:0]       w_age;
    logic [TIME_BITS-1:0]       w_interval;
    logic [COUNT_BITS:0]        w_half_sum;
    logic signed [POS_BITS-1:0] w_half;
    logic signed [POS_BITS-1:0] w_pos;
    logic                       w_div_done;
    logic [QUO_BITS-1:0]        w_quotient;
    logic [SPEED_BITS-1:0]      w_inst;
    logic [AVG_BITS+1:0]        w_avg_sum;
    logic [SPEED_BITS-1:0]      w_speed;
    logic [SPEED_BITS:0]        w_speed_x;
    logic [1:0]                 w_tier;

    assign w_age      = r_now - r_latest_time;
    assign w_interval = r_latest_time - r_older_time;

    // Halve toward zero: add one to negative counts before the shift.
    assign w_half_sum = {r_edge_count[COUNT_BITS-1], r_edge_count}
                      + (COUNT_BITS + 1)'(r_edge_count[COUNT_BITS-1]);
    assign w_half     = w_half_sum[POS_BITS:1];

    // Negating the most negative half does not fit and saturates.
    always_comb begin
        if (!r_invert) begin
            w_pos = w_half;
        end else if (w_half == {1'b1, {(POS_BITS - 1){1'b0}}}) begin
            w_pos = {1'b0, {(POS_BITS - 1){1'b1}}};
        end else begin
            w_pos = -w_half;
        end
    end

    rei_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_divisor  (w_interval[QUO_BITS-1:0]),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Average in 1/256 units: (3 * avg + 256 * inst) / 4.
    assign w_inst    = r_inst_ok ? w_quotient : '0;
    assign w_avg_sum = (AVG_BITS + 2)'(r_avg) + (AVG_BITS + 2)'({r_avg, 1'b0})
                     + (AVG_BITS + 2)'({w_inst, 8'd0});
    assign w_speed   = r_avg[SPEED_BITS+7:8];
    assign w_speed_x = {1'b0, w_speed};

    // Tier hysteresis: compare with the band added on one side or the other.
    always_comb begin
        case (r_tier)
            TIER_SLOW: begin
                w_tier = (w_speed_x >= (SPEED_BITS + 1)'(r_medium) + (SPEED_BITS + 1)'(r_band))
                       ? TIER_MEDIUM : TIER_SLOW;
            end
            TIER_MEDIUM: begin
                if (w_speed_x + (SPEED_BITS + 1)'(r_band) < (SPEED_BITS + 1)'(r_medium)) begin
                    w_tier = TIER_SLOW;
                end else if (w_speed_x >=
                             (SPEED_BITS + 1)'(r_fast) + (SPEED_BITS + 1)'(r_band)) begin
                    w_tier = TIER_FAST;
                end else begin
                    w_tier = TIER_MEDIUM;
                end
            end
            default: begin
                w_tier = (w_speed_x + (SPEED_BITS + 1)'(r_band) < (SPEED_BITS + 1)'(r_fast))
                       ? TIER_MEDIUM : TIER_FAST;
            end
        endcase
    end

    // The last step waits only if the previous result is still unclaimed.
    assign w_fin_go = (r_state == S_FIN) && (!o_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_div_start <= 1'b0;
            r_avg       <= '0;
            r_tier      <= TIER_SLOW;
        end else begin
            r_div_start <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && i_req_type == REQ_READ) begin
                        r_state <= S_AGE;
                    end
                end
                S_AGE: begin
                    r_state <= S_INTV;
                end
                S_INTV: begin
                    r_div_start <= 1'b1;
                    r_state     <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_AVG;
                    end
                end
                S_AVG: begin
                    r_avg   <= r_stale ? '0 : w_avg_sum[AVG_BITS+1:2];
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_fin_go) begin
                        r_tier  <= w_tier;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_AGE) begin
            r_stale <= (r_edges_seen == 2'd0) || (w_age >= TIME_BITS'(r_stale_time));
        end
        if (r_state == S_INTV) begin
            r_inst_ok <= (r_edges_seen == 2'd2) && (w_interval != '0) &&
                         (w_interval[TIME_BITS-1:QUO_BITS] == '0);
            r_pos     <= w_pos;
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds a finished result until the consumer takes it.
    // ------------------------------------------------------------------
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_go) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_go) begin
            o_position     <= r_pos;
            o_pressed      <= r_btn_level;
            o_btn_event    <= r_btn_flag;
            o_smooth_speed <= w_speed;
            o_speed_tier   <= w_tier;
        end
    end

    assign o_valid = r_out_valid;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide step");

    a_fin_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_go |=> o_valid && r_state == S_IDLE)
        else $error("finished read did not present a result");

    a_tier_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_speed_tier <= TIER_FAST)
        else $error("illegal speed tier on result");

    a_flag_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_go |=> !r_btn_flag)
        else $error("button change flag survived its read");

endmodule

`default_nettype wire

// ===== hdl/rei_div.sv =====
// ---------------------------------------------------------------------------
// Rotary encoder speed divider
// Restoring divider that forms the speed numerator over a narrow divisor,
// one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rei_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [rei_pkg::QUO_BITS-1:0] i_divisor,
    output logic                              o_done,
    output logic [rei_pkg::QUO_BITS-1:0]      o_quotient
);
    import rei_pkg::*;

    localparam int CNT_W = $clog2(QUO_BITS);
    localparam logic [QUO_BITS-1:0] NUM = QUO_BITS'(SPEED_NUM);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [QUO_BITS-1:0] r_rem;
    logic [QUO_BITS-1:0] r_quo;
    logic [QUO_BITS-1:0] r_div;

    logic [QUO_BITS:0]   w_trial;
    logic [QUO_BITS:0]   w_diff;
    logic                w_ge;

    // Bring down the next numerator bit and try one subtraction.
    assign w_trial = {r_rem, NUM[r_cnt]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNT_W'(QUO_BITS - 1);
            r_rem <= '0;
            r_quo <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_rem <= w_ge ? w_diff[QUO_BITS-1:0] : w_trial[QUO_BITS-1:0];
            r_quo <= {r_quo[QUO_BITS-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire
